### src/irpd_pkg.sv
// shared types and constants for the ir pulse distance decoder
package irpd_pkg;

    localparam int CODE_BITS_DEFAULT = 32;
    localparam int DUR_W = 16;
    localparam int TOL_W = 12;
    localparam int POS_W = 6;
    localparam int WORD_W = 32;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [TOL_W-1:0] TOLERANCE_RESET = 12'd599;
    localparam logic [DUR_W-1:0] NOM_600 = 16'd600;
    localparam logic [DUR_W-1:0] NOM_1600 = 16'd1600;
    localparam logic [DUR_W-1:0] NOM_4500 = 16'd4500;
    localparam logic [DUR_W-1:0] NOM_9000 = 16'd9000;
    localparam logic [POS_W-1:0] POS_MAX = 6'd63;

    // register index decoded from paddr[2]
    localparam logic REG_TOLERANCE = 1'b0;

    typedef enum logic [2:0] {
        CLS_NONE = 3'd0,
        CLS_600 = 3'd1,
        CLS_1600 = 3'd2,
        CLS_4500 = 3'd3,
        CLS_9000 = 3'd4
    } cls_t;

    typedef enum logic [1:0] {
        SYM_HEADER = 2'd0,
        SYM_ZERO = 2'd1,
        SYM_ONE = 2'd2,
        SYM_END = 2'd3
    } sym_t;

    typedef struct packed {
        logic [DUR_W-1:0] duration_us;
        logic frame_start;
    } item_t;

    typedef struct packed {
        logic [1:0] symbol;
        logic [WORD_W-1:0] code_word;
        logic [POS_W-1:0] pair_position;
        logic last;
    } result_t;

endpackage

### src/irpd_classify.sv
// duration classifier, first matching nominal width wins
module irpd_classify
    import irpd_pkg::*;
(
    input  logic [DUR_W-1:0] duration_us,
    input  logic [TOL_W-1:0] tolerance_us,
    output cls_t cls
);

    function automatic logic near(input logic [DUR_W-1:0] d, input logic [DUR_W-1:0] nom,
                                  input logic [TOL_W-1:0] tol);
        logic [DUR_W-1:0] delta;
        begin
            delta = (d >= nom) ? (d - nom) : (nom - d);
            near = delta < {{(DUR_W-TOL_W){1'b0}}, tol};
        end
    endfunction

    always_comb
    begin
        priority if (near(duration_us, NOM_600, tolerance_us))
        begin
            cls = CLS_600;
        end
        else if (near(duration_us, NOM_1600, tolerance_us))
        begin
            cls = CLS_1600;
        end
        else if (near(duration_us, NOM_4500, tolerance_us))
        begin
            cls = CLS_4500;
        end
        else if (near(duration_us, NOM_9000, tolerance_us))
        begin
            cls = CLS_9000;
        end
        else
        begin
            cls = CLS_NONE;
        end
    end

endmodule

### src/ir_pulse_distance_decoder.sv
// top level of the ir pulse distance decoder
// Pulse distance remote decoder. Each duration transfer is classed against
// 600/1600/4500/9000 us within tolerance_us, durations are paired, and every
// completed pair yields one result transfer: header, bit zero, bit one or end
// of frame, with the code word assembled so far (most significant bit first)
// and the pair position. One duration is taken every clock cycle unless
// item_stall holds it while a result is stalled; a result passes the input
// register, then the result register. After an end of frame, durations are
// dropped until one arrives with frame_start set. tolerance_us is written
// over the APB port at address 0.
module ir_pulse_distance_decoder
    import irpd_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    output logic item_stall,
    input  item_t item,
    output logic result_valid,
    input  logic result_stall,
    output result_t result,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic pready
);

    localparam int IDX_W = $clog2(CODE_BITS);
    localparam logic [POS_W:0] CODE_BITS_W = (POS_W+1)'(CODE_BITS);

    logic [TOL_W-1:0] tol_reg;
    logic in_valid_reg;
    item_t in_reg;
    logic second_half_reg, second_half_next;
    cls_t first_class_reg, first_class_next;
    logic [CODE_BITS-1:0] code_reg, code_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic frame_ended_reg, frame_ended_next;
    logic result_valid_reg;
    result_t result_reg, result_next;

    logic advance, fire, produce;
    cls_t cls;
    sym_t sym;
    logic sh_base;
    cls_t fc_base;
    logic [CODE_BITS-1:0] code_base;
    logic [POS_W-1:0] pos_base;
    logic fe_base;
    logic [POS_W:0] bit_sel;
    logic [IDX_W-1:0] bit_idx;
    logic [WORD_W-1:0] word;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TOLERANCE) ? {{(DATA_W-TOL_W){1'b0}}, tol_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOLERANCE_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_TOLERANCE)
        begin
            tol_reg <= pwdata[TOL_W-1:0];
        end
    end

    // handshake
    assign advance = !result_valid_reg || !result_stall;
    assign item_stall = in_valid_reg && !advance;
    assign fire = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
        begin
            in_reg <= item;
        end
    end

    irpd_classify u_classify
    (
        .duration_us(in_reg.duration_us),
        .tolerance_us(tol_reg),
        .cls(cls)
    );

    always_comb
    begin
        if (in_reg.frame_start)
        begin
            sh_base = 1'b0;
            fc_base = CLS_NONE;
            code_base = '0;
            pos_base = '0;
            fe_base = 1'b0;
        end
        else
        begin
            sh_base = second_half_reg;
            fc_base = first_class_reg;
            code_base = code_reg;
            pos_base = pos_reg;
            fe_base = frame_ended_reg;
        end
    end

    always_comb
    begin
        priority if (fc_base == CLS_600 && cls == CLS_600)
        begin
            sym = SYM_ZERO;
        end
        else if (fc_base == CLS_600 && cls == CLS_1600)
        begin
            sym = SYM_ONE;
        end
        else if (fc_base == CLS_9000 && cls == CLS_4500)
        begin
            sym = SYM_HEADER;
        end
        else
        begin
            sym = SYM_END;
        end
    end

    assign bit_sel = CODE_BITS_W - {1'b0, pos_base};
    assign bit_idx = bit_sel[IDX_W-1:0];

    always_comb
    begin
        second_half_next = second_half_reg;
        first_class_next = first_class_reg;
        code_next = code_reg;
        pos_next = pos_reg;
        frame_ended_next = frame_ended_reg;
        produce = 1'b0;
        if (fire && !fe_base)
        begin
            code_next = code_base;
            pos_next = pos_base;
            frame_ended_next = fe_base;
            if (!sh_base)
            begin
                first_class_next = cls;
                second_half_next = 1'b1;
            end
            else
            begin
                produce = 1'b1;
                first_class_next = fc_base;
                second_half_next = 1'b0;
                if ((sym == SYM_ZERO || sym == SYM_ONE) && pos_base != '0
                    && {1'b0, pos_base} <= CODE_BITS_W)
                begin
                    code_next[bit_idx] = (sym == SYM_ONE);
                end
                if (pos_base < POS_MAX)
                begin
                    pos_next = pos_base + 1'b1;
                end
                if (sym == SYM_END)
                begin
                    frame_ended_next = 1'b1;
                end
            end
        end
    end

    generate
        if (CODE_BITS >= WORD_W)
        begin : g_word_wide
            assign word = code_next[WORD_W-1:0];
        end
        else
        begin : g_word_narrow
            assign word = {{(WORD_W-CODE_BITS){1'b0}}, code_next};
        end
    endgenerate

    always_comb
    begin
        result_next.symbol = sym;
        result_next.code_word = word;
        result_next.pair_position = pos_base;
        result_next.last = (sym == SYM_END);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_half_reg <= 1'b0;
            first_class_reg <= CLS_NONE;
            code_reg <= '0;
            pos_reg <= '0;
            frame_ended_reg <= 1'b1;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            second_half_reg <= second_half_next;
            first_class_reg <= first_class_next;
            code_reg <= code_next;
            pos_reg <= pos_next;
            frame_ended_reg <= frame_ended_next;
            if (advance)
            begin
                result_valid_reg <= produce;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result = result_reg;

endmodule
